FILE: rtl/bbf_pkg.sv
// Package for the buddy bitmap free block finder.
// Holds field widths, payload structs, controller state and command/status types.
// No dependencies.
`default_nettype none

package bbf_pkg;

    localparam int PAGE_W  = 13;
    localparam int FIRST_W = 12;
    localparam int WIDX_W  = 7;
    localparam int ORD_W   = 4;
    localparam int WORD_W  = 32;
    localparam int WSEL_W  = PAGE_W - 5;
    localparam int ADDR_W  = 3;

    localparam int DEF_MAX_PAGES = 4096;
    localparam int DEF_MAX_ORDER = 10;
    localparam int PC_RESET      = 4096;

    localparam logic       REQ_UPDATE     = 1'b0;
    localparam logic       REQ_FIND       = 1'b1;
    localparam logic       REG_PAGE_COUNT = 1'b0;

    typedef struct packed {
        logic                req_type;
        logic [WIDX_W-1:0]   word_index;
        logic [WORD_W-1:0]   busy_word;
        logic [ORD_W-1:0]    order;
        logic [FIRST_W-1:0]  first_page;
        logic [PAGE_W-1:0]   limit_page;
    } req_t;

    typedef struct packed {
        logic              found;
        logic [PAGE_W-1:0] page;
    } rsp_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic clr;
        logic take;
        logic start;
        logic load_now;
        logic scan;
        logic load_res;
    } ctl_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic go;
        logic out_free;
        logic scan_done;
    } ctl_sts_t;

endpackage

`default_nettype wire

FILE: rtl/bbf_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`default_nettype none

module bbf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/bbf_ctrl.sv
// Controller state machine of the free block finder.
// Depends on bbf_pkg.
`default_nettype none

module bbf_ctrl
    import bbf_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_stall,
    input  wire ctl_sts_t sts,
    output ctl_cmd_t      cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_stall  = 1'b1;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                req_stall = !sts.out_free;
                if (req_valid && sts.out_free)
                begin
                    cmd.take = 1'b1;
                    if (sts.go)
                    begin
                        cmd.start  = 1'b1;
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        cmd.load_now = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                if (sts.out_free)
                begin
                    cmd.load_res = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/bbf_dp.sv
// Datapath of the free block finder: page count, busy word store, word scan and result register.
// Depends on bbf_pkg and bbf_ram.
`default_nettype none

module bbf_dp
    import bbf_pkg::*;
#(
    parameter int MAX_PAGES = DEF_MAX_PAGES,
    parameter int MAX_ORDER = DEF_MAX_ORDER
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ctl_cmd_t          cmd,
    output ctl_sts_t               sts,
    input  wire req_t              req,
    input  wire logic              cfg_we,
    input  wire logic [PAGE_W-1:0] cfg_data,
    output logic      [PAGE_W-1:0] page_count,
    output rsp_t                   rsp,
    output logic                   rsp_valid,
    input  wire logic              rsp_stall
);

    localparam int DEPTH = MAX_PAGES / 32;
    localparam int AW    = $clog2(DEPTH);
    localparam int PC_INIT = (PC_RESET > MAX_PAGES) ? MAX_PAGES : PC_RESET;

    logic [PAGE_W-1:0]  pc_reg;
    logic [AW-1:0]      clr_reg;
    logic [ORD_W-1:0]   ord_reg;
    logic [PAGE_W-1:0]  first_al_reg;
    logic [PAGE_W-1:0]  end_page_reg;
    logic [WSEL_W-1:0]  last_w_reg;
    logic [WSEL_W-1:0]  dw_reg;
    logic               run_reg;
    logic               res_found_reg;
    logic [PAGE_W-1:0]  res_page_reg;
    rsp_t               rsp_reg;
    logic               rsp_valid_reg;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [WORD_W-1:0]  ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [WORD_W-1:0]  ram_rdata;

    logic [16:0]        blk_m1;
    logic [16:0]        begin_b;
    logic [PAGE_W-1:0]  end_l;
    logic [PAGE_W-1:0]  end_c;
    logic [PAGE_W-1:0]  end_b;
    logic               args_ok;
    logic               find_go;
    logic [PAGE_W-1:0]  first_al;
    logic [PAGE_W-1:0]  end_page;
    logic [PAGE_W-1:0]  last_page;
    logic               upd_ok;

    logic [WORD_W-1:0]  lo_mask;
    logic [WORD_W-1:0]  hi_mask;
    logic [PAGE_W-1:0]  n_hi;
    logic [5:0]         hi_sh;
    logic [WORD_W-1:0]  m;
    logic [WORD_W-1:0]  f;
    logic [WORD_W-1:0]  al;
    logic [WORD_W-1:0]  fa;
    logic [4:0]         omask;
    logic [4:0]         lo_idx;
    logic               ord_short;
    logic [WSEL_W-1:0]  wm;
    logic               cur;
    logic               hit;
    logic [PAGE_W-1:0]  hit_page;
    logic [PAGE_W-1:0]  cfg_sat;

    always_comb
    begin
        blk_m1    = (17'd1 << req.order) - 17'd1;
        begin_b   = (17'(req.first_page) + blk_m1) >> req.order;
        end_l     = req.limit_page >> req.order;
        end_c     = pc_reg >> req.order;
        end_b     = (end_l < end_c) ? end_l : end_c;
        args_ok   = (32'(req.order) <= 32'(MAX_ORDER)) && (req.limit_page <= pc_reg)
                    && (PAGE_W'(req.first_page) < req.limit_page);
        find_go   = args_ok && (begin_b < 17'(end_b));
        first_al  = PAGE_W'(begin_b << req.order);
        end_page  = PAGE_W'(end_b << req.order);
        last_page = end_page - PAGE_W'(1);
        upd_ok    = 32'(req.word_index) < 32'(DEPTH);
    end

    always_comb
    begin
        lo_mask = '1;
        if (dw_reg == first_al_reg[PAGE_W-1:5])
        begin
            lo_mask = 32'hFFFF_FFFF << first_al_reg[4:0];
        end
        n_hi    = end_page_reg - {dw_reg, 5'b0};
        hi_sh   = 6'd32 - n_hi[5:0];
        hi_mask = '1;
        if (dw_reg == last_w_reg)
        begin
            hi_mask = 32'hFFFF_FFFF >> hi_sh;
        end
        m = ~ram_rdata & lo_mask & hi_mask;

        f = m;
        for (int s = 0; s < 5; s++)
        begin
            if (32'(ord_reg) > s)
            begin
                f = f & (f >> (32'd1 << s));
            end
        end
        ord_short = ord_reg <= 4'd5;
        omask = ord_short ? 5'((6'd1 << ord_reg[2:0]) - 6'd1) : 5'h1f;
        for (int j = 0; j < WORD_W; j++)
        begin
            al[j] = (5'(j) & omask) == 5'd0;
        end
        fa = f & al;
        lo_idx = 5'd0;
        for (int j = WORD_W - 1; j >= 0; j--)
        begin
            if (fa[j])
            begin
                lo_idx = 5'(j);
            end
        end

        wm  = ord_short ? '0 : WSEL_W'((16'd1 << (ord_reg - 4'd5)) - 16'd1);
        cur = (((dw_reg & wm) == '0) ? 1'b1 : run_reg) && (m == '1);
        hit = ord_short ? (|fa) : (cur && ((dw_reg & wm) == wm));
        hit_page = ord_short ? {dw_reg, lo_idx} : {dw_reg & ~wm, 5'b0};

        cfg_sat = (32'(cfg_data) > 32'(MAX_PAGES)) ? PAGE_W'(MAX_PAGES) : cfg_data;
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = AW'(req.word_index);
        ram_wdata = req.busy_word;
        if (cmd.clr)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_reg;
            ram_wdata = '1;
        end
        else if (cmd.take && req.req_type == REQ_UPDATE && upd_ok)
        begin
            ram_we = 1'b1;
        end
        ram_raddr = cmd.take ? AW'(first_al[PAGE_W-1:5]) : AW'(dw_reg + WSEL_W'(1));
    end

    bbf_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= PAGE_W'(PC_INIT);
            clr_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                pc_reg <= cfg_sat;
            end
            if (cmd.clr)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (cmd.load_now || cmd.load_res)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            ord_reg      <= req.order;
            first_al_reg <= first_al;
            end_page_reg <= end_page;
            last_w_reg   <= last_page[PAGE_W-1:5];
            dw_reg       <= first_al[PAGE_W-1:5];
            run_reg      <= 1'b0;
        end
        else if (cmd.scan)
        begin
            dw_reg  <= dw_reg + WSEL_W'(1);
            run_reg <= cur;
            if (hit || dw_reg == last_w_reg)
            begin
                res_found_reg <= hit;
                res_page_reg  <= hit ? hit_page : pc_reg;
            end
        end
        if (cmd.load_now)
        begin
            rsp_reg.found <= 1'b0;
            rsp_reg.page  <= pc_reg;
        end
        else if (cmd.load_res)
        begin
            rsp_reg.found <= res_found_reg;
            rsp_reg.page  <= res_page_reg;
        end
    end

    assign sts.clr_last  = clr_reg == AW'(DEPTH - 1);
    assign sts.go        = (req.req_type == REQ_FIND) && find_go;
    assign sts.out_free  = !rsp_valid_reg || !rsp_stall;
    assign sts.scan_done = hit || (dw_reg == last_w_reg);
    assign page_count    = pc_reg;
    assign rsp           = rsp_reg;
    assign rsp_valid     = rsp_valid_reg;

endmodule

`default_nettype wire

FILE: rtl/buddy_bitmap_free_block_finder.sv
// Buddy bitmap free block finder: request channel, result channel, APB register port.
// Requests either write one 32-bit busy word (one page per bit, set means busy) or ask
// for the lowest free naturally aligned block of 2^order pages inside [first, limit).
// A block of order k counts as free when all of its pages are free, which is exactly
// what the per-order summary bits of a buddy allocator record.
// Every item gives one result item: found and page, or found 0 and page_count.
// An update or a rejected find is taken while idle and its result shows the next cycle.
// A find is started, then scans the busy words one by one (up to 128 words for the
// default size), and then loads the result; the scan reads one word a cycle
// from the single read port of the busy store.
// After reset the busy store is swept to all ones, all MAX_PAGES/32 words (128 by default),
// and req_stall stays high until the sweep ends; page_count resets to the smaller of 4096 and MAX_PAGES.
// While rsp_stall holds the result, a new item is not taken; the result register then
// keeps its value until it is taken.
// Depends on bbf_pkg, bbf_ctrl, bbf_dp.
`default_nettype none

module buddy_bitmap_free_block_finder
    import bbf_pkg::*;
#(
    parameter int MAX_PAGES = DEF_MAX_PAGES,
    parameter int MAX_ORDER = DEF_MAX_ORDER
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_stall,
    input  wire req_t              req,
    output logic                   rsp_valid,
    input  wire logic              rsp_stall,
    output rsp_t                   rsp,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready
);

    ctl_cmd_t          cmd;
    ctl_sts_t          sts;
    logic              cfg_we;
    logic [PAGE_W-1:0] page_count;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_PAGE_COUNT);
    assign prdata = (paddr[2] == REG_PAGE_COUNT) ? 32'(page_count) : 32'd0;

    bbf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    bbf_dp #(
        .MAX_PAGES (MAX_PAGES),
        .MAX_ORDER (MAX_ORDER)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .req        (req),
        .cfg_we     (cfg_we),
        .cfg_data   (pwdata[PAGE_W-1:0]),
        .page_count (page_count),
        .rsp        (rsp),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall)
    );

endmodule

`default_nettype wire

FILE: rtl/bbf_checker.sv
// Port-level checker for the buddy bitmap free block finder, bound to the top level.
// Depends on bbf_pkg.
`default_nettype none

module bbf_checker
    import bbf_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic req_valid,
    input wire logic req_stall,
    input wire logic rsp_valid,
    input wire logic rsp_stall,
    input wire rsp_t rsp,
    input wire logic pready
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid)
        else $error("result item dropped while stalled");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> $stable(rsp))
        else $error("result item changed while stalled");

    a_no_take_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall && req_valid |-> req_stall)
        else $error("item taken while result register is held");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("register port not ready");

endmodule

bind buddy_bitmap_free_block_finder bbf_checker u_bbf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .pready    (pready)
);

`default_nettype wire
